/* rtl/kci_pkg.sv */
// Shared types, constants and the cosine-ease table for the keyframe interpolator.
`default_nettype none

package kci_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int TIME_W   = 31;
  localparam int PROP_W   = 8;
  localparam int VAL_W    = 32;
  localparam int FRAC_W   = 10;
  localparam int NUM_W    = 41;
  localparam int DEN_W    = 31;
  localparam int EASE_N   = 1001;
  localparam int SCALE    = 1000;
  localparam int K_MANT   = 13180600;

  // floor(2^36/125)+1 and floor(2^30/1000)+1, reciprocals for the blend scaling
  localparam logic [29:0] RCP125  = 30'd549755814;
  localparam logic [20:0] RCP1000 = 21'd1073742;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_CLEARED = 3'd2,
    ST_NOKEY   = 3'd3,
    ST_SINGLE  = 3'd4,
    ST_INTERP  = 3'd5,
    ST_BADGAP  = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [TIME_W-1:0]       time_stamp;
    logic [PROP_W-1:0]       prop_id;
    logic signed [VAL_W-1:0] prop_value;
  } in_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] value_out;
  } out_t;

  typedef struct packed {
    logic [TIME_W-1:0]       tstamp;
    logic [PROP_W-1:0]       prop;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  typedef enum logic [1:0] {
    SM_NONE = 2'd0,
    SM_SCAN = 2'd1,
    SM_BACK = 2'd2,
    SM_FWD  = 2'd3
  } search_mode_t;

  typedef enum logic [1:0] {
    DS_FRAC  = 2'd0,
    DS_RIGHT = 2'd1,
    DS_LEFT  = 2'd2
  } div_sel_t;

  typedef struct packed {
    search_mode_t mode;
    logic         init;
    logic         ld_num;
    logic         div_start;
    div_sel_t     div_sel;
    logic         ld_ease;
    logic         ld_prod;
    logic         res_load;
    status_t      res_status;
  } ctl_t;

  typedef struct packed {
    logic search_done;
    logic empty;
    logic has_l;
    logic has_r;
    logic gap_bad;
    logic div_done;
  } stat_t;

  typedef struct packed {
    logic [63:0] q;
    logic [7:0]  s;
  } rnd_t;

  function automatic rnd_t round24(input logic [63:0] v, input logic sticky);
    rnd_t        r;
    int          len;
    int          s;
    logic [63:0] q;
    logic [63:0] rm;
    logic [63:0] half;
    len = 0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) len = i + 1;
    end
    if (len <= 24) begin
      r.q = v;
      r.s = '0;
      return r;
    end
    s    = len - 24;
    q    = v >> s;
    rm   = v & ((64'd1 << s) - 64'd1);
    half = 64'd1 << (s - 1);
    if (rm > half || (rm == half && (sticky || q[0]))) q = q + 64'd1;
    if ((q >> 24) != 64'd0) begin
      q = q >> 1;
      s = s + 1;
    end
    r.q = q;
    r.s = 8'(s);
    return r;
  endfunction

  function automatic logic [63:0] fmul60(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return p[123:60];
  endfunction

  function automatic logic [FRAC_W-1:0] ease_entry(input int f);
    rnd_t        r1;
    rnd_t        r2;
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] a60;
    logic [63:0] b;
    logic [63:0] b2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] sq;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] v;
    logic        sticky;
    int          e;
    if (f == 0) return '0;
    r1     = round24(64'(f) * 64'(K_MANT), 1'b0);
    num    = r1.q << 40;
    quo    = num / 64'(SCALE);
    sticky = (num % 64'(SCALE)) != 64'd0;
    r2     = round24(quo, sticky);
    e      = int'(r1.s) + int'(r2.s) - 2;
    if (e >= 0) a60 = (e < 40) ? (r2.q << e) : 64'd0;
    else        a60 = (-e < 64) ? (r2.q >> (-e)) : 64'd0;
    b    = a60 >> 1;
    b2   = fmul60(b, b);
    sum  = b;
    term = b;
    for (int k = 1; k <= 20; k++) begin
      term = fmul60(term, b2) / 64'((2 * k) * (2 * k + 1));
      if (k[0]) sum = sum - term;
      else      sum = sum + term;
    end
    sq = fmul60(sum, sum);
    hi = sq >> 30;
    lo = sq & 64'h3FFF_FFFF;
    v  = (hi * 64'(SCALE) + ((lo * 64'(SCALE)) >> 30)) >> 30;
    if (v > 64'(SCALE)) v = 64'(SCALE);
    return v[FRAC_W-1:0];
  endfunction

  typedef logic [FRAC_W-1:0] ease_tab_t [EASE_N];

  function automatic ease_tab_t build_ease();
    ease_tab_t t;
    for (int i = 0; i < EASE_N; i++) begin
      t[i] = ease_entry(i);
    end
    return t;
  endfunction

  localparam ease_tab_t EASE_TAB = build_ease();

endpackage

`default_nettype wire

/* rtl/kci_div.sv */
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none

module kci_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [kci_pkg::NUM_W-1:0] num,
  input  logic [kci_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [kci_pkg::NUM_W-1:0] quot
);
  import kci_pkg::*;

  localparam int STEP_W = $clog2(NUM_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W:0]    shifted;
  logic              fits;

  assign shifted = {rem, quot[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quot  <= num;
      den_r <= den;
    end else if (busy) begin
      rem  <= fits ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

/* rtl/kci_dpath.sv */
// Keyframe table, search counters, blend arithmetic and result register.
`default_nettype none

module kci_dpath (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  kci_pkg::in_t   item,
  input  kci_pkg::ctl_t  ctl,
  output kci_pkg::stat_t st,
  output logic           strobe,
  output kci_pkg::out_t  result
);
  import kci_pkg::*;

  entry_t mem [CAPACITY];
  entry_t rdata;

  logic [CNT_W-1:0]  cnt;
  logic              full;
  logic              add_ok;
  logic [TIME_W-1:0] q_t;
  logic [PROP_W-1:0] q_p;

  logic [CNT_W-1:0]  idx;
  logic              iss_end;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;
  logic [TIME_W-1:0] last;
  logic [IDX_W-1:0]  origin;
  logic              has_l;
  logic              has_r;
  logic [TIME_W-1:0] tl;
  logic [TIME_W-1:0] tr;
  logic signed [VAL_W-1:0] vl;
  logic signed [VAL_W-1:0] vr;

  logic time_gt;
  logic match;
  logic rd_last;
  logic ev;
  logic issue;
  logic search_done;

  logic [TIME_W-1:0] gap;
  logic [TIME_W-1:0] off;
  logic [TIME_W-1:0] offc;
  logic [NUM_W-1:0]  num_f;
  logic [NUM_W-1:0]  num;
  logic              frac_go;
  logic              frac_done;
  logic              div_done;
  logic [NUM_W-1:0]  quot;

  logic [FRAC_W-1:0] frac;
  logic [FRAC_W-1:0] ease;
  logic [FRAC_W-1:0] inv_ease;
  logic [VAL_W-1:0]  ar;
  logic [VAL_W-1:0]  al;
  logic [VAL_W-1:0]  pr_mag;
  logic [VAL_W-1:0]  pl_mag;
  logic              pr_neg;
  logic              pl_neg;

  logic                sc_go;
  logic [4:0]          sc_v;
  logic [VAL_W-1:0]    sc_a;
  logic [FRAC_W-1:0]   sc_w;
  logic [57:0]         sc_p1;
  logic [21:0]         sc_q;
  logic [VAL_W-1:0]    sc_qk;
  logic [VAL_W-1:0]    sc_rem;
  logic [FRAC_W-1:0]   sc_r;
  logic [VAL_W-1:0]    sc_qw;
  logic [2*FRAC_W-1:0] sc_t;
  logic [40:0]         sc_p2;
  logic [VAL_W-1:0]    sc_out;

  logic [VAL_W-1:0]  qr;
  logic [VAL_W-1:0]  ql;
  logic signed [VAL_W:0]   sr;
  logic signed [VAL_W:0]   sl;
  logic signed [VAL_W+1:0] blend;

  assign full   = cnt == CNT_W'(CAPACITY);
  assign add_ok = accept && item.cmd == CMD_ADD && !full;

  always_ff @(posedge clk) begin
    if (add_ok) begin
      mem[cnt[IDX_W-1:0]] <= '{tstamp: item.time_stamp, prop: item.prop_id,
                               value: item.prop_value};
    end
    rdata <= mem[idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept && item.cmd == CMD_CLEAR) begin
      cnt <= '0;
    end else if (add_ok) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_t <= item.time_stamp;
      q_p <= item.prop_id;
    end
  end

  assign time_gt = rdata.tstamp > q_t;
  assign match   = rdata.prop == q_p;
  assign rd_last = {1'b0, rd_idx} == cnt - CNT_W'(1);
  assign ev      = rd_vld && !ctl.init;

  always_comb begin
    case (ctl.mode)
      SM_SCAN: begin
        issue       = !ctl.init && idx < cnt;
        search_done = cnt == '0 || (ev && (time_gt || rd_last));
      end
      SM_BACK: begin
        issue       = !ctl.init && !iss_end;
        search_done = ev && (match || rd_idx == '0);
      end
      SM_FWD: begin
        issue       = !ctl.init && idx < cnt;
        search_done = (ev && (match || rd_last)) || (!ctl.init && !rd_vld && idx >= cnt);
      end
      default: begin
        issue       = 1'b0;
        search_done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) rd_idx <= idx[IDX_W-1:0];
    if (ctl.init) begin
      case (ctl.mode)
        SM_SCAN: begin
          idx    <= '0;
          last   <= '0;
          origin <= '0;
        end
        SM_BACK: begin
          idx     <= {1'b0, origin};
          iss_end <= 1'b0;
          has_l   <= 1'b0;
        end
        SM_FWD: begin
          idx   <= {1'b0, origin} + CNT_W'(1);
          has_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end else if (issue) begin
      case (ctl.mode)
        SM_BACK: begin
          if (idx == '0) iss_end <= 1'b1;
          else           idx     <= idx - CNT_W'(1);
        end
        default: idx <= idx + CNT_W'(1);
      endcase
    end
    if (ev) begin
      case (ctl.mode)
        SM_SCAN: begin
          if (!time_gt && rdata.tstamp > last) begin
            last   <= rdata.tstamp;
            origin <= rd_idx;
          end
        end
        SM_BACK: begin
          if (match && !has_l) begin
            has_l <= 1'b1;
            tl    <= rdata.tstamp;
            vl    <= rdata.value;
          end
        end
        SM_FWD: begin
          if (match && !has_r) begin
            has_r <= 1'b1;
            tr    <= rdata.tstamp;
            vr    <= rdata.value;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign gap   = tr - tl;
  assign off   = (q_t < tl) ? '0 : q_t - tl;
  assign offc  = (off > gap) ? gap : off;
  assign num_f = NUM_W'(offc) * NUM_W'(SCALE);

  assign frac_go = ctl.div_start && ctl.div_sel == DS_FRAC;
  assign sc_go   = ctl.div_start && ctl.div_sel != DS_FRAC;

  kci_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (frac_go),
    .num   (num),
    .den   (gap),
    .done  (frac_done),
    .quot  (quot)
  );

  assign inv_ease = FRAC_W'(SCALE) - ease;
  assign ar       = vr[VAL_W-1] ? VAL_W'(-vr) : VAL_W'(vr);
  assign al       = vl[VAL_W-1] ? VAL_W'(-vl) : VAL_W'(vl);

  // floor(a*w/1000) as q*w + floor(r*w/1000), with a = 1000*q + r
  assign sc_p1  = {29'd0, sc_a[VAL_W-1:3]} * {28'd0, RCP125};
  assign sc_qk  = {10'd0, sc_q} * VAL_W'(SCALE);
  assign sc_rem = sc_a - sc_qk;
  assign sc_p2  = {21'd0, sc_t} * {20'd0, RCP1000};

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_v <= '0;
    end else begin
      sc_v <= {sc_v[3:0], sc_go};
    end
  end

  always_ff @(posedge clk) begin
    if (sc_go) begin
      sc_a <= (ctl.div_sel == DS_LEFT) ? pl_mag : pr_mag;
      sc_w <= (ctl.div_sel == DS_LEFT) ? inv_ease : ease;
    end
    sc_q   <= sc_p1[57:36];
    sc_r   <= sc_rem[FRAC_W-1:0];
    sc_qw  <= {10'd0, sc_q} * {22'd0, sc_w};
    sc_t   <= {10'd0, sc_r} * {10'd0, sc_w};
    sc_out <= sc_qw + {22'd0, sc_p2[39:30]};
  end

  assign div_done = frac_done || sc_v[4];

  always_ff @(posedge clk) begin
    if (ctl.ld_num) num <= num_f;
    if (div_done) begin
      case (ctl.div_sel)
        DS_RIGHT: qr   <= sc_out;
        DS_LEFT:  ql   <= sc_out;
        default:  frac <= quot[FRAC_W-1:0];
      endcase
    end
    if (ctl.ld_ease) ease <= EASE_TAB[frac];
    if (ctl.ld_prod) begin
      pr_mag <= ar;
      pl_mag <= al;
      pr_neg <= vr[VAL_W-1];
      pl_neg <= vl[VAL_W-1];
    end
  end

  assign sr    = pr_neg ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
  assign sl    = pl_neg ? -$signed({1'b0, ql}) : $signed({1'b0, ql});
  assign blend = (VAL_W+2)'(sr) + (VAL_W+2)'(sl);

  assign st.search_done = search_done;
  assign st.empty       = cnt == '0;
  assign st.has_l       = has_l;
  assign st.has_r       = has_r;
  assign st.gap_bad     = tr <= tl;
  assign st.div_done    = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (accept && item.cmd != CMD_QUERY) || ctl.res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.cmd != CMD_QUERY) begin
      result.value_out <= '0;
      case (item.cmd)
        CMD_CLEAR: result.status <= ST_CLEARED;
        CMD_ADD:   result.status <= full ? ST_FULL : ST_ADDED;
        default:   result.status <= ST_NOKEY;
      endcase
    end else if (ctl.res_load) begin
      result.status <= ctl.res_status;
      case (ctl.res_status)
        ST_SINGLE: result.value_out <= has_l ? vl : vr;
        ST_INTERP: result.value_out <= blend[VAL_W-1:0];
        default:   result.value_out <= '0;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/kci_ctrl.sv */
// Query sequencer: seek, backward and forward search, divide and blend steps.
`default_nettype none

module kci_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [1:0]     cmd,
  input  kci_pkg::stat_t st,
  output kci_pkg::ctl_t  ctl,
  output logic           busy
);
  import kci_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_BACK,
    S_FWD,
    S_EVAL,
    S_FMUL,
    S_DIVF,
    S_EASE,
    S_PROD,
    S_DIVR,
    S_DIVL,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  ctl_t   ctl_next;

  always_comb begin
    state_next = state;
    ctl_next   = '0;
    case (state)
      S_IDLE: begin
        if (accept && cmd == CMD_QUERY) begin
          state_next    = S_SCAN;
          ctl_next.init = 1'b1;
        end
      end
      S_SCAN: begin
        if (st.search_done) begin
          if (st.empty) begin
            state_next          = S_DONE;
            ctl_next.res_load   = 1'b1;
            ctl_next.res_status = ST_NOKEY;
          end else begin
            state_next    = S_BACK;
            ctl_next.init = 1'b1;
          end
        end
      end
      S_BACK: begin
        if (st.search_done) begin
          state_next    = S_FWD;
          ctl_next.init = 1'b1;
        end
      end
      S_FWD: begin
        if (st.search_done) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (!st.has_l && !st.has_r) begin
          state_next          = S_DONE;
          ctl_next.res_load   = 1'b1;
          ctl_next.res_status = ST_NOKEY;
        end else if (!st.has_l || !st.has_r) begin
          state_next          = S_DONE;
          ctl_next.res_load   = 1'b1;
          ctl_next.res_status = ST_SINGLE;
        end else if (st.gap_bad) begin
          state_next          = S_DONE;
          ctl_next.res_load   = 1'b1;
          ctl_next.res_status = ST_BADGAP;
        end else begin
          state_next      = S_FMUL;
          ctl_next.ld_num = 1'b1;
        end
      end
      S_FMUL: begin
        state_next         = S_DIVF;
        ctl_next.div_start = 1'b1;
      end
      S_DIVF: begin
        if (st.div_done) begin
          state_next       = S_EASE;
          ctl_next.ld_ease = 1'b1;
        end
      end
      S_EASE: begin
        state_next       = S_PROD;
        ctl_next.ld_prod = 1'b1;
      end
      S_PROD: begin
        state_next         = S_DIVR;
        ctl_next.div_start = 1'b1;
      end
      S_DIVR: begin
        if (st.div_done) begin
          state_next         = S_DIVL;
          ctl_next.div_start = 1'b1;
        end
      end
      S_DIVL: begin
        if (st.div_done) begin
          state_next          = S_DONE;
          ctl_next.res_load   = 1'b1;
          ctl_next.res_status = ST_INTERP;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    case (state_next)
      S_SCAN:  ctl_next.mode = SM_SCAN;
      S_BACK:  ctl_next.mode = SM_BACK;
      S_FWD:   ctl_next.mode = SM_FWD;
      default: ctl_next.mode = SM_NONE;
    endcase

    case (state_next)
      S_DIVR:  ctl_next.div_sel = DS_RIGHT;
      S_DIVL:  ctl_next.div_sel = DS_LEFT;
      default: ctl_next.div_sel = DS_FRAC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ctl   <= '0;
    end else begin
      state <= state_next;
      ctl   <= ctl_next;
    end
  end

  assign busy = state != S_IDLE;

endmodule

`default_nettype wire

/* rtl/keyframe_cosine_interpolator.sv */
// Top level of the keyframe table with cosine-eased interpolation.
// Clear, add and unused commands: result strobe one cycle after the accepting edge; busy stays low.
// Query: busy while the seek, backward and forward searches read the table (one table read per
// cycle), then through one serial divide for the fraction and two reciprocal scalings.
// Result strobe in the first cycle with busy low. Reset empties the table at once.
`default_nettype none

module keyframe_cosine_interpolator (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  kci_pkg::in_t  item,
  output logic          strobe,
  output kci_pkg::out_t result
);
  import kci_pkg::*;

  logic  accept;
  ctl_t  ctl;
  stat_t st;

  assign accept = start && !busy;

  kci_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (item.cmd),
    .st     (st),
    .ctl    (ctl),
    .busy   (busy)
  );

  kci_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .ctl    (ctl),
    .st     (st),
    .strobe (strobe),
    .result (result)
  );

endmodule

`default_nettype wire

/* rtl/kci_chk.sv */
// Port-level checks of the keyframe interpolator, bound to the top level.
`default_nettype none

module kci_chk (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input kci_pkg::in_t  item,
  input logic          strobe,
  input kci_pkg::out_t result
);
  import kci_pkg::*;

  a_busy_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && item.cmd == CMD_QUERY))
    else $error("busy rose without a query beat");

  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd != CMD_QUERY) |=> strobe)
    else $error("no result beat after a table command");

  a_query_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> strobe)
    else $error("query finished without a result beat");

  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.status != ST_SINGLE && result.status != ST_INTERP)
      |-> result.value_out == '0)
    else $error("value on a result beat that carries none");

endmodule

bind keyframe_cosine_interpolator kci_chk u_chk (.*);

`default_nettype wire
